// ===== src/bpf_pkg.sv =====
// Shared types, codes and helpers of the Bezier path flattener.
package bpf_pkg;

	localparam int COORD_BITS = 24;
	localparam int DEF_MAX_DEPTH = 6;
	localparam logic [15:0] TOL_RESET = 16'd64;
	localparam logic [15:0] TOL_MIN = 16'd3;

	localparam logic [2:0] OP_MOVE = 3'd0;
	localparam logic [2:0] OP_LINE = 3'd1;
	localparam logic [2:0] OP_QUAD = 3'd2;
	localparam logic [2:0] OP_CUBIC = 3'd3;
	localparam logic [2:0] OP_CLOSE = 3'd4;
	localparam logic [2:0] OP_END = 3'd5;

	localparam logic [1:0] K_OPEN = 2'd0;
	localparam logic [1:0] K_CONT = 2'd1;
	localparam logic [1:0] K_KEEP = 2'd2;
	localparam logic [1:0] K_DISCARD = 2'd3;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		logic [2:0] op;
		coord_t pt0_x;
		coord_t pt0_y;
		coord_t pt1_x;
		coord_t pt1_y;
		coord_t pt2_x;
		coord_t pt2_y;
	} cmd_t;

	typedef struct packed {
		coord_t out_x;
		coord_t out_y;
		logic [1:0] kind;
		logic last;
	} res_t;

	// Chord start, control point and chord end for one flatness test.
	typedef struct packed {
		coord_t ax;
		coord_t ay;
		coord_t px;
		coord_t py;
		coord_t dx;
		coord_t dy;
	} ch_pts_t;

	typedef struct packed {
		logic idle;
		logic done;
		logic near;
	} ch_stat_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_MARK_PRE, ST_POINT, ST_MARK,
		ST_CTEST1, ST_CTEST2, ST_SPLIT1, ST_SPLIT2, ST_CEMIT
	} state_t;

	typedef enum logic [3:0] {
		CH_IDLE, CH_LEN, CH_ZERO, CH_M1, CH_M2, CH_CROSS, CH_SQ, CH_RHS, CH_DONE
	} ch_state_t;

	// Midpoint of two coordinates, rounded toward minus infinity.
	function automatic coord_t mid(input coord_t u, input coord_t v);
		logic signed [COORD_BITS:0] s;
		s = {u[COORD_BITS-1], u} + {v[COORD_BITS-1], v};
		return s[COORD_BITS:1];
	endfunction

endpackage

// ===== src/bezier_path_flattener.sv =====
// Top level of the Bezier path flattener: command sequencer and curve splitter.
//
// Commands enter on cmd/cmd_valid/cmd_stall, one word at a time; results
// leave on res/res_valid/res_stall. A word is taken when valid is high and
// stall is low. tol_we/tol_data write the flatness tolerance at any edge.
// A curve walks a depth-first split stack of MAX_DEPTH entries; each flatness
// test runs on the shared multiplier in bpf_chord (a cubic piece may need two),
// each split goes through ST_SPLIT1 and ST_SPLIT2 and each flat piece emits one
// point. cmd_stall is high from the cycle after a word that yields results is
// taken until its last result has been loaded into the output register; a close
// or end of path with no points pending, or an unknown op, leaves it low. The
// output register holds a result while res_stall is high, and the sequencer
// waits with it. Reset clears the pen, contour start, last point and point count
// to zero, empties the output register and sets the tolerance to 64.
module bezier_path_flattener #(
	parameter int MAX_DEPTH = bpf_pkg::DEF_MAX_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input bpf_pkg::cmd_t cmd,
	input logic cmd_valid,
	output logic cmd_stall,
	output bpf_pkg::res_t res,
	output logic res_valid,
	input logic res_stall,
	input logic tol_we,
	input logic [15:0] tol_data
);
	localparam int LW = $clog2(MAX_DEPTH + 1);
	localparam int LIW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int SIW = $clog2(3 * MAX_DEPTH);
	localparam int SDEPTH = 3 * MAX_DEPTH;

	bpf_pkg::state_t state_q, state_nxt;
	bpf_pkg::coord_t pen_x_q, pen_y_q, start_x_q, start_y_q, lp_x_q, lp_y_q;
	bpf_pkg::coord_t pt_x_q, pt_y_q;
	bpf_pkg::coord_t a_x_q, a_y_q, b_x_q, b_y_q, c_x_q, c_y_q, d_x_q, d_y_q;
	bpf_pkg::coord_t ab_x_q, ab_y_q, bc_x_q, bc_y_q, cd_x_q, cd_y_q;
	bpf_pkg::coord_t stk_x_q [SDEPTH];
	bpf_pkg::coord_t stk_y_q [SDEPTH];
	logic [LW-1:0] stk_lvl_q [MAX_DEPTH];
	logic [LW-1:0] lvl_q, sp_q, spm1;
	logic [SIW-1:0] push_base, pop_base;
	logic [1:0] cnt_q;
	logic then_mark_q, cubic_q;
	logic [15:0] tol_q, tol_eff;
	logic [31:0] tol2_q;
	bpf_pkg::res_t res_q, res_nxt;
	logic res_valid_q;
	logic can_emit, emit, ch_start, at_max;
	bpf_pkg::ch_pts_t ch_pts;
	bpf_pkg::ch_stat_t ch_stat;
	bpf_pkg::coord_t abc_x, abc_y, bcd_x, bcd_y;

	// Shared flatness test unit.
	bpf_chord u_chord (
		.clk(clk),
		.arst_n(arst_n),
		.start(ch_start),
		.pts(ch_pts),
		.tol2(tol2_q),
		.stat(ch_stat)
	);

	// Stack addressing and second split level.
	always_comb begin
		spm1 = sp_q - LW'(1);
		push_base = SIW'(sp_q[LIW-1:0]) * SIW'(3);
		pop_base = SIW'(spm1[LIW-1:0]) * SIW'(3);
		at_max = (lvl_q >= LW'(MAX_DEPTH));
		tol_eff = (tol_q < bpf_pkg::TOL_MIN) ? bpf_pkg::TOL_MIN : tol_q;
		abc_x = bpf_pkg::mid(ab_x_q, bc_x_q);
		abc_y = bpf_pkg::mid(ab_y_q, bc_y_q);
		bcd_x = bpf_pkg::mid(bc_x_q, cd_x_q);
		bcd_y = bpf_pkg::mid(bc_y_q, cd_y_q);
	end

	// Next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			bpf_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					case (cmd.op) inside
						bpf_pkg::OP_MOVE: begin
							state_nxt = (cnt_q != 2'd0) ? bpf_pkg::ST_MARK_PRE : bpf_pkg::ST_POINT;
						end
						bpf_pkg::OP_LINE: state_nxt = bpf_pkg::ST_POINT;
						bpf_pkg::OP_QUAD, bpf_pkg::OP_CUBIC: state_nxt = bpf_pkg::ST_CTEST1;
						bpf_pkg::OP_CLOSE: begin
							if (cnt_q != 2'd0) begin
								state_nxt = (lp_x_q != start_x_q || lp_y_q != start_y_q) ?
									bpf_pkg::ST_POINT : bpf_pkg::ST_MARK;
							end
						end
						bpf_pkg::OP_END: begin
							if (cnt_q != 2'd0) state_nxt = bpf_pkg::ST_MARK;
						end
						default: state_nxt = bpf_pkg::ST_IDLE;
					endcase
				end
			end
			bpf_pkg::ST_MARK_PRE: if (emit) state_nxt = bpf_pkg::ST_POINT;
			bpf_pkg::ST_POINT: begin
				if (emit) state_nxt = then_mark_q ? bpf_pkg::ST_MARK : bpf_pkg::ST_IDLE;
			end
			bpf_pkg::ST_MARK: if (emit) state_nxt = bpf_pkg::ST_IDLE;
			bpf_pkg::ST_CTEST1: begin
				if (at_max) begin
					state_nxt = bpf_pkg::ST_CEMIT;
				end else if (ch_stat.done) begin
					if (!ch_stat.near) state_nxt = bpf_pkg::ST_SPLIT1;
					else state_nxt = cubic_q ? bpf_pkg::ST_CTEST2 : bpf_pkg::ST_CEMIT;
				end
			end
			bpf_pkg::ST_CTEST2: begin
				if (ch_stat.done) begin
					state_nxt = ch_stat.near ? bpf_pkg::ST_CEMIT : bpf_pkg::ST_SPLIT1;
				end
			end
			bpf_pkg::ST_SPLIT1: state_nxt = bpf_pkg::ST_SPLIT2;
			bpf_pkg::ST_SPLIT2: state_nxt = bpf_pkg::ST_CTEST1;
			bpf_pkg::ST_CEMIT: begin
				if (emit) state_nxt = (sp_q == '0) ? bpf_pkg::ST_IDLE : bpf_pkg::ST_CTEST1;
			end
			default: state_nxt = bpf_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the sequencer: result word, emit strobe and chord start.
	always_comb begin
		can_emit = !res_valid_q || !res_stall;
		emit = 1'b0;
		res_nxt = res_q;
		ch_start = 1'b0;
		ch_pts.ax = a_x_q;
		ch_pts.ay = a_y_q;
		ch_pts.px = (state_q == bpf_pkg::ST_CTEST2) ? c_x_q : b_x_q;
		ch_pts.py = (state_q == bpf_pkg::ST_CTEST2) ? c_y_q : b_y_q;
		ch_pts.dx = d_x_q;
		ch_pts.dy = d_y_q;
		unique case (state_q)
			bpf_pkg::ST_MARK_PRE, bpf_pkg::ST_MARK: begin
				emit = can_emit;
				res_nxt.out_x = '0;
				res_nxt.out_y = '0;
				res_nxt.kind = (cnt_q >= 2'd2) ? bpf_pkg::K_KEEP : bpf_pkg::K_DISCARD;
				res_nxt.last = (state_q == bpf_pkg::ST_MARK);
			end
			bpf_pkg::ST_POINT: begin
				emit = can_emit;
				res_nxt.out_x = pt_x_q;
				res_nxt.out_y = pt_y_q;
				res_nxt.kind = (cnt_q == 2'd0) ? bpf_pkg::K_OPEN : bpf_pkg::K_CONT;
				res_nxt.last = !then_mark_q;
			end
			bpf_pkg::ST_CEMIT: begin
				emit = can_emit;
				res_nxt.out_x = d_x_q;
				res_nxt.out_y = d_y_q;
				res_nxt.kind = (cnt_q == 2'd0) ? bpf_pkg::K_OPEN : bpf_pkg::K_CONT;
				res_nxt.last = (sp_q == '0);
			end
			bpf_pkg::ST_CTEST1: ch_start = ch_stat.idle && !at_max;
			bpf_pkg::ST_CTEST2: ch_start = ch_stat.idle;
			default: emit = 1'b0;
		endcase
	end

	assign cmd_stall = (state_q != bpf_pkg::ST_IDLE);
	assign res = res_q;
	assign res_valid = res_valid_q;

	// Control state, contour state and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bpf_pkg::ST_IDLE;
			res_valid_q <= 1'b0;
			cnt_q <= 2'd0;
			pen_x_q <= '0;
			pen_y_q <= '0;
			start_x_q <= '0;
			start_y_q <= '0;
			lp_x_q <= '0;
			lp_y_q <= '0;
			tol_q <= bpf_pkg::TOL_RESET;
			tol2_q <= 32'(bpf_pkg::TOL_RESET) * 32'(bpf_pkg::TOL_RESET);
		end else begin
			state_q <= state_nxt;
			tol2_q <= 32'(tol_eff) * 32'(tol_eff);
			if (tol_we) tol_q <= tol_data;
			if (emit) res_valid_q <= 1'b1;
			else if (!res_stall) res_valid_q <= 1'b0;
			// Point count follows every emitted word; the last point follows every emitted point.
			if (emit) begin
				if (state_q == bpf_pkg::ST_MARK_PRE || state_q == bpf_pkg::ST_MARK) begin
					cnt_q <= 2'd0;
				end else begin
					if (cnt_q != 2'd3) cnt_q <= cnt_q + 2'd1;
					lp_x_q <= res_nxt.out_x;
					lp_y_q <= res_nxt.out_y;
				end
			end
			// Pen and contour start move when a command word is taken.
			if (state_q == bpf_pkg::ST_IDLE && cmd_valid) begin
				case (cmd.op)
					bpf_pkg::OP_MOVE: begin
						pen_x_q <= cmd.pt0_x;
						pen_y_q <= cmd.pt0_y;
						start_x_q <= cmd.pt0_x;
						start_y_q <= cmd.pt0_y;
					end
					bpf_pkg::OP_LINE: begin
						pen_x_q <= cmd.pt0_x;
						pen_y_q <= cmd.pt0_y;
					end
					bpf_pkg::OP_QUAD: begin
						pen_x_q <= cmd.pt1_x;
						pen_y_q <= cmd.pt1_y;
					end
					bpf_pkg::OP_CUBIC: begin
						pen_x_q <= cmd.pt2_x;
						pen_y_q <= cmd.pt2_y;
					end
					bpf_pkg::OP_CLOSE: begin
						pen_x_q <= start_x_q;
						pen_y_q <= start_y_q;
					end
					bpf_pkg::OP_END: begin
						pen_x_q <= '0;
						pen_y_q <= '0;
						start_x_q <= '0;
						start_y_q <= '0;
					end
					default: pen_x_q <= pen_x_q;
				endcase
			end
		end
	end

	// Curve walk depth and stack pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q <= '0;
			sp_q <= '0;
		end else if (state_q == bpf_pkg::ST_IDLE) begin
			lvl_q <= '0;
			sp_q <= '0;
		end else if (state_q == bpf_pkg::ST_SPLIT2) begin
			lvl_q <= lvl_q + LW'(1);
			sp_q <= sp_q + LW'(1);
		end else if (state_q == bpf_pkg::ST_CEMIT && emit && sp_q != '0) begin
			lvl_q <= stk_lvl_q[spm1[LIW-1:0]];
			sp_q <= spm1;
		end
	end

	// Curve points, split results and the split stack.
	always_ff @(posedge clk) begin
		if (state_q == bpf_pkg::ST_IDLE && cmd_valid) begin
			cubic_q <= (cmd.op == bpf_pkg::OP_CUBIC);
			then_mark_q <= (cmd.op == bpf_pkg::OP_CLOSE);
			pt_x_q <= (cmd.op == bpf_pkg::OP_CLOSE) ? start_x_q : cmd.pt0_x;
			pt_y_q <= (cmd.op == bpf_pkg::OP_CLOSE) ? start_y_q : cmd.pt0_y;
			a_x_q <= pen_x_q;
			a_y_q <= pen_y_q;
			b_x_q <= cmd.pt0_x;
			b_y_q <= cmd.pt0_y;
			if (cmd.op == bpf_pkg::OP_CUBIC) begin
				c_x_q <= cmd.pt1_x;
				c_y_q <= cmd.pt1_y;
				d_x_q <= cmd.pt2_x;
				d_y_q <= cmd.pt2_y;
			end else begin
				c_x_q <= '0;
				c_y_q <= '0;
				d_x_q <= cmd.pt1_x;
				d_y_q <= cmd.pt1_y;
			end
		end
		// First split level.
		if (state_q == bpf_pkg::ST_SPLIT1) begin
			ab_x_q <= bpf_pkg::mid(a_x_q, b_x_q);
			ab_y_q <= bpf_pkg::mid(a_y_q, b_y_q);
			bc_x_q <= cubic_q ? bpf_pkg::mid(b_x_q, c_x_q) : bpf_pkg::mid(b_x_q, d_x_q);
			bc_y_q <= cubic_q ? bpf_pkg::mid(b_y_q, c_y_q) : bpf_pkg::mid(b_y_q, d_y_q);
			cd_x_q <= bpf_pkg::mid(c_x_q, d_x_q);
			cd_y_q <= bpf_pkg::mid(c_y_q, d_y_q);
		end
		// Push the right half, keep the left half.
		if (state_q == bpf_pkg::ST_SPLIT2) begin
			stk_lvl_q[sp_q[LIW-1:0]] <= lvl_q + LW'(1);
			stk_x_q[push_base + SIW'(2)] <= d_x_q;
			stk_y_q[push_base + SIW'(2)] <= d_y_q;
			b_x_q <= ab_x_q;
			b_y_q <= ab_y_q;
			if (cubic_q) begin
				stk_x_q[push_base] <= bcd_x;
				stk_y_q[push_base] <= bcd_y;
				stk_x_q[push_base + SIW'(1)] <= cd_x_q;
				stk_y_q[push_base + SIW'(1)] <= cd_y_q;
				c_x_q <= abc_x;
				c_y_q <= abc_y;
				d_x_q <= bpf_pkg::mid(abc_x, bcd_x);
				d_y_q <= bpf_pkg::mid(abc_y, bcd_y);
			end else begin
				stk_x_q[push_base] <= bc_x_q;
				stk_y_q[push_base] <= bc_y_q;
				stk_x_q[push_base + SIW'(1)] <= '0;
				stk_y_q[push_base + SIW'(1)] <= '0;
				d_x_q <= bpf_pkg::mid(ab_x_q, bc_x_q);
				d_y_q <= bpf_pkg::mid(ab_y_q, bc_y_q);
			end
		end
		// Flat piece emitted: advance the chord start and pop the next half.
		if (state_q == bpf_pkg::ST_CEMIT && emit) begin
			a_x_q <= d_x_q;
			a_y_q <= d_y_q;
			if (sp_q != '0) begin
				b_x_q <= stk_x_q[pop_base];
				b_y_q <= stk_y_q[pop_base];
				c_x_q <= stk_x_q[pop_base + SIW'(1)];
				c_y_q <= stk_y_q[pop_base + SIW'(1)];
				d_x_q <= stk_x_q[pop_base + SIW'(2)];
				d_y_q <= stk_y_q[pop_base + SIW'(2)];
			end
		end
		if (emit) res_q <= res_nxt;
	end

endmodule

// ===== src/bpf_chord.sv =====
// Flatness test of one control point against a chord on a shared multiplier.
module bpf_chord (
	input logic clk,
	input logic arst_n,
	input logic start,
	input bpf_pkg::ch_pts_t pts,
	input logic [31:0] tol2,
	output bpf_pkg::ch_stat_t stat
);
	localparam int C = bpf_pkg::COORD_BITS;
	localparam int H = C + 1;
	localparam int W2 = 2 * H;
	localparam int W4 = 4 * H;

	bpf_pkg::ch_state_t state_q, state_nxt;
	logic [1:0] k_q;
	logic [W4-1:0] acc_q, c2_q;
	logic [W2-1:0] len2_q, m1_q, m2_q, cr_q;
	logic near_q;

	logic signed [H-1:0] ex, ey, qx, qy;
	logic [H-1:0] ex_m, ey_m, qx_m, qy_m;
	logic [H-1:0] mul_a, mul_b;
	logic [1:0] units;
	logic [W2-1:0] prod;
	logic [W4-1:0] pp, acc_sum;
	logic [W2:0] cr_w;
	logic n1, n2, ovf;

	// Chord and control point differences and their magnitudes.
	always_comb begin
		ex = {pts.dx[C-1], pts.dx} - {pts.ax[C-1], pts.ax};
		ey = {pts.dy[C-1], pts.dy} - {pts.ay[C-1], pts.ay};
		qx = {pts.ax[C-1], pts.ax} - {pts.px[C-1], pts.px};
		qy = {pts.ay[C-1], pts.ay} - {pts.py[C-1], pts.py};
		ex_m = ex[H-1] ? H'(-ex) : H'(ex);
		ey_m = ey[H-1] ? H'(-ey) : H'(ey);
		qx_m = qx[H-1] ? H'(-qx) : H'(qx);
		qy_m = qy[H-1] ? H'(-qy) : H'(qy);
		n1 = ex[H-1] ^ qy[H-1];
		n2 = qx[H-1] ^ ey[H-1];
	end

	// Operand selection; wide products go limb by limb.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		units = 2'd0;
		case (state_q)
			bpf_pkg::CH_LEN: begin
				mul_a = k_q[0] ? ey_m : ex_m;
				mul_b = k_q[0] ? ey_m : ex_m;
			end
			bpf_pkg::CH_ZERO: begin
				mul_a = k_q[0] ? qy_m : qx_m;
				mul_b = k_q[0] ? qy_m : qx_m;
			end
			bpf_pkg::CH_M1: begin
				mul_a = ex_m;
				mul_b = qy_m;
			end
			bpf_pkg::CH_M2: begin
				mul_a = qx_m;
				mul_b = ey_m;
			end
			bpf_pkg::CH_SQ: begin
				mul_a = k_q[1] ? cr_q[W2-1:H] : cr_q[H-1:0];
				mul_b = k_q[0] ? cr_q[W2-1:H] : cr_q[H-1:0];
				units = {1'b0, k_q[1]} + {1'b0, k_q[0]};
			end
			bpf_pkg::CH_RHS: begin
				mul_a = k_q[1] ? len2_q[W2-1:H] : len2_q[H-1:0];
				mul_b = k_q[0] ? H'(W2'(tol2) >> H) : H'(tol2);
				units = {1'b0, k_q[1]} + {1'b0, k_q[0]};
			end
			default: begin
				mul_a = '0;
			end
		endcase
	end

	// Multiplier, shift into place and accumulate.
	always_comb begin
		prod = W2'(mul_a) * W2'(mul_b);
		case (units)
			2'd0: pp = W4'(prod);
			2'd1: pp = W4'(prod) << H;
			default: pp = W4'(prod) << (2 * H);
		endcase
		acc_sum = ((k_q == 2'd0) ? W4'(0) : acc_q) + pp;
	end

	// Cross product magnitude from the two partial products.
	always_comb begin
		if (n1 == n2) begin
			cr_w = (m1_q >= m2_q) ? {1'b0, m1_q - m2_q} : {1'b0, m2_q - m1_q};
		end else begin
			cr_w = {1'b0, m1_q} + {1'b0, m2_q};
		end
		ovf = (cr_w >> 52) != '0;
	end

	// Next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			bpf_pkg::CH_IDLE: if (start) state_nxt = bpf_pkg::CH_LEN;
			bpf_pkg::CH_LEN: begin
				if (k_q == 2'd1) begin
					state_nxt = (acc_sum == '0) ? bpf_pkg::CH_ZERO : bpf_pkg::CH_M1;
				end
			end
			bpf_pkg::CH_ZERO: if (k_q == 2'd1) state_nxt = bpf_pkg::CH_DONE;
			bpf_pkg::CH_M1: state_nxt = bpf_pkg::CH_M2;
			bpf_pkg::CH_M2: state_nxt = bpf_pkg::CH_CROSS;
			bpf_pkg::CH_CROSS: state_nxt = ovf ? bpf_pkg::CH_DONE : bpf_pkg::CH_SQ;
			bpf_pkg::CH_SQ: if (k_q == 2'd3) state_nxt = bpf_pkg::CH_RHS;
			bpf_pkg::CH_RHS: if (k_q == 2'd3) state_nxt = bpf_pkg::CH_DONE;
			bpf_pkg::CH_DONE: state_nxt = bpf_pkg::CH_IDLE;
			default: state_nxt = bpf_pkg::CH_IDLE;
		endcase
	end

	// Status toward the sequencer.
	always_comb begin
		stat.idle = (state_q == bpf_pkg::CH_IDLE);
		stat.done = (state_q == bpf_pkg::CH_DONE);
		stat.near = near_q;
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bpf_pkg::CH_IDLE;
			k_q <= 2'd0;
		end else begin
			state_q <= state_nxt;
			if ((state_q == bpf_pkg::CH_LEN || state_q == bpf_pkg::CH_ZERO) && k_q == 2'd1) begin
				k_q <= 2'd0;
			end else if (state_q == bpf_pkg::CH_LEN || state_q == bpf_pkg::CH_ZERO ||
					state_q == bpf_pkg::CH_SQ || state_q == bpf_pkg::CH_RHS) begin
				k_q <= k_q + 2'd1;
			end else begin
				k_q <= 2'd0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		acc_q <= acc_sum;
		if (state_q == bpf_pkg::CH_LEN && k_q == 2'd1) len2_q <= acc_sum[W2-1:0];
		if (state_q == bpf_pkg::CH_ZERO && k_q == 2'd1) near_q <= (acc_sum <= W4'(tol2));
		if (state_q == bpf_pkg::CH_M1) m1_q <= prod;
		if (state_q == bpf_pkg::CH_M2) m2_q <= prod;
		if (state_q == bpf_pkg::CH_CROSS) begin
			cr_q <= cr_w[W2-1:0];
			if (ovf) near_q <= 1'b0;
		end
		if (state_q == bpf_pkg::CH_SQ && k_q == 2'd3) c2_q <= acc_sum;
		if (state_q == bpf_pkg::CH_RHS && k_q == 2'd3) near_q <= (c2_q <= acc_sum);
	end

endmodule
